// ===== hw/rtl/cos_sim_pkg.sv =====
// ----------------------------------------------------------------------------
// cos_sim_pkg
// shared constants and types for the cosine similarity block
// ----------------------------------------------------------------------------
package cos_sim_pkg;

    localparam int ELEM_WIDTH = 16;
    localparam int ACC_WIDTH  = 48;
    localparam int SCORE_WIDTH = 16;
    localparam int QUEUE_DEPTH = 4;

    // sums handed from the accumulator to the scoring unit
    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] dot;
        logic signed [ACC_WIDTH-1:0] na;
        logic signed [ACC_WIDTH-1:0] nb;
    } t_sums;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_SUM,
        S_CMP,
        S_DONE
    } t_score_state;

endpackage

// ===== hw/rtl/cos_sim_acc.sv =====
// ----------------------------------------------------------------------------
// cos_sim_acc
// front part: squares and products of each pair, saturating running sums
// ----------------------------------------------------------------------------
module cos_sim_acc #(
    parameter int ELEM_W = cos_sim_pkg::ELEM_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic signed [ELEM_W-1:0]  i_a,
    input  logic signed [ELEM_W-1:0]  i_b,
    input  logic                      i_last,
    output logic                      o_valid,
    output cos_sim_pkg::t_sums        o_sums
);
    localparam int AW = cos_sim_pkg::ACC_WIDTH;
    localparam int PW = 2 * ELEM_W;
    localparam int SW = ((AW > PW) ? AW : PW) + 2;

    // stage 1: registered products
    logic                  r_pv, r_plast;
    logic signed [PW-1:0]  r_ab, r_aa, r_bb;
    // stage 2: sums
    logic signed [AW-1:0]  r_dot, r_na, r_nb;
    logic signed [AW-1:0]  n_dot, n_na, n_nb;
    logic                  r_ov;

    function automatic logic signed [AW-1:0] sat_add(
        input logic signed [AW-1:0] acc, input logic signed [PW-1:0] p);
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] mx;
        s  = SW'(acc) + SW'(p);
        mx = SW'({1'b0, {(AW-1){1'b1}}});
        if (s > mx) return {1'b0, {(AW-1){1'b1}}};
        if (s < -mx - SW'(1)) return {1'b1, {(AW-1){1'b0}}};
        return s[AW-1:0];
    endfunction

    assign n_dot = sat_add(r_dot, r_ab);
    assign n_na  = sat_add(r_na, r_aa);
    assign n_nb  = sat_add(r_nb, r_bb);

    always_ff @(posedge i_clk) begin
        r_ab <= i_a * i_b;
        r_aa <= i_a * i_a;
        r_bb <= i_b * i_b;
        r_plast <= i_last;
        o_sums.dot <= n_dot;
        o_sums.na  <= n_na;
        o_sums.nb  <= n_nb;
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
        end else begin
            r_pv <= i_valid;
            r_ov <= r_pv && r_plast;
            if (r_pv) begin
                if (r_plast) begin
                    r_dot <= '0;
                    r_na  <= '0;
                    r_nb  <= '0;
                end else begin
                    r_dot <= n_dot;
                    r_na  <= n_na;
                    r_nb  <= n_nb;
                end
            end
        end
    end

    assign o_valid = r_ov;
endmodule

// ===== hw/rtl/cos_sim_fifo.sv =====
// ----------------------------------------------------------------------------
// cos_sim_fifo
// short queue between accumulation and scoring
// ----------------------------------------------------------------------------
module cos_sim_fifo #(
    parameter int DEPTH = cos_sim_pkg::QUEUE_DEPTH,
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic [WIDTH-1:0] o_data
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    function automatic logic [IW-1:0] inc(input logic [IW-1:0] p);
        return (p == IW'(DEPTH-1)) ? '0 : p + IW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= inc(r_wr);
            if (i_pop)  r_rd <= inc(r_rd);
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
endmodule

// ===== hw/rtl/cos_sim_score.sv =====
// ----------------------------------------------------------------------------
// cos_sim_score
// back part: digit-serial norm products, then a shift-add search for the
// q15 score, one bit per pass
// ----------------------------------------------------------------------------
module cos_sim_score (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  cos_sim_pkg::t_sums       i_sums,
    output logic                     o_take,
    output logic                     o_valid,
    output logic signed [cos_sim_pkg::SCORE_WIDTH-1:0] o_score,
    output logic                     o_zero_norm,
    input  logic                     i_ready
);
    localparam int AW = cos_sim_pkg::ACC_WIDTH;
    localparam int DW = AW / 2;
    localparam int FB = cos_sim_pkg::SCORE_WIDTH - 1;
    localparam int QW = cos_sim_pkg::SCORE_WIDTH + 1;
    localparam int PW = 2 * AW;
    localparam int XW = PW + 2 * QW;

    cos_sim_pkg::t_score_state r_st, n_st;

    logic [AW-1:0]   r_na, r_nb, r_ad;
    logic            r_neg, r_zero;
    logic [1:0]      r_k;
    logic [PW-1:0]   r_rhs;
    logic [XW-1:0]   r_r2, r_s, r_t, r_lhs;
    logic [QW-1:0]   r_q;
    logic [3:0]      r_bit;
    logic [QW-1:0]   w_t;
    logic [QW-1:0]   w_mag;
    logic [DW-1:0]   w_nx, w_ny, w_dx, w_dy;
    logic [2*DW-1:0] w_pn, w_pd;
    logic [PW-1:0]   w_sn, w_sd;

    assign w_t = r_q | (QW'(1) << r_bit);

    // one pair of half-width digits per step, four steps per product
    assign w_nx = r_k[1] ? r_na[AW-1:DW] : r_na[DW-1:0];
    assign w_ny = r_k[0] ? r_nb[AW-1:DW] : r_nb[DW-1:0];
    assign w_dx = r_k[1] ? r_ad[AW-1:DW] : r_ad[DW-1:0];
    assign w_dy = r_k[0] ? r_ad[AW-1:DW] : r_ad[DW-1:0];
    assign w_pn = w_nx * w_ny;
    assign w_pd = w_dx * w_dy;

    always_comb begin
        case (r_k)
            2'd0: begin
                w_sn = PW'(w_pn);
                w_sd = PW'(w_pd);
            end
            2'd3: begin
                w_sn = PW'(w_pn) << (2 * DW);
                w_sd = PW'(w_pd) << (2 * DW);
            end
            default: begin
                w_sn = PW'(w_pn) << DW;
                w_sd = PW'(w_pd) << DW;
            end
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            cos_sim_pkg::S_IDLE: if (i_valid) n_st = cos_sim_pkg::S_PROD;
            cos_sim_pkg::S_PROD: begin
                if (r_zero)           n_st = cos_sim_pkg::S_DONE;
                else if (r_k == 2'd3) n_st = cos_sim_pkg::S_SUM;
            end
            cos_sim_pkg::S_SUM:  n_st = cos_sim_pkg::S_CMP;
            cos_sim_pkg::S_CMP:  n_st = (r_bit == '0) ? cos_sim_pkg::S_DONE
                                                      : cos_sim_pkg::S_SUM;
            cos_sim_pkg::S_DONE: if (i_ready) n_st = cos_sim_pkg::S_IDLE;
            default:             n_st = cos_sim_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_take  = (r_st == cos_sim_pkg::S_IDLE) && i_valid;
        o_valid = (r_st == cos_sim_pkg::S_DONE);
    end

    // trial term prod*t^2 kept as r2 + s + t with r2 = prod*q^2,
    // s = prod*q << (bit+1) and t = prod << 2*bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= cos_sim_pkg::S_IDLE;
        else          r_st <= n_st;
        case (r_st)
            cos_sim_pkg::S_IDLE: begin
                r_na   <= i_sums.na;
                r_nb   <= i_sums.nb;
                r_neg  <= i_sums.dot[AW-1];
                r_ad   <= i_sums.dot[AW-1] ? AW'(-i_sums.dot) : AW'(i_sums.dot);
                r_zero <= (i_sums.na == '0) || (i_sums.nb == '0);
                r_q    <= '0;
                r_bit  <= 4'(FB);
                r_k    <= '0;
                r_rhs  <= '0;
                r_r2   <= '0;
                r_s    <= '0;
                r_t    <= '0;
            end
            cos_sim_pkg::S_PROD: begin
                // sums of squares are never negative
                r_rhs <= r_rhs + w_sd;
                r_t   <= r_t + (XW'(w_sn) << (2 * FB));
                r_k   <= r_k + 2'd1;
            end
            cos_sim_pkg::S_SUM: r_lhs <= r_r2 + r_s + r_t;
            cos_sim_pkg::S_CMP: begin
                if (r_lhs <= (XW'(r_rhs) << (2 * FB))) begin
                    r_q  <= w_t;
                    r_r2 <= r_lhs;
                    r_s  <= (r_s >> 1) + r_t;
                end else begin
                    r_s  <= r_s >> 1;
                end
                r_t   <= r_t >> 2;
                r_bit <= r_bit - 4'd1;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_mag = r_q;
        if (r_zero) begin
            o_score     = 16'sh8000;
            o_zero_norm = 1'b1;
        end else begin
            o_zero_norm = 1'b0;
            if (r_neg) begin
                if (w_mag > QW'(32768)) w_mag = QW'(32768);
                o_score = 16'(-w_mag);
            end else begin
                if (w_mag > QW'(32767)) w_mag = QW'(32767);
                o_score = 16'(w_mag);
            end
        end
    end
endmodule

// ===== hw/rtl/cosine_similarity_top.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_top
// streaming cosine similarity of two q4.12 vectors, q1.15 score
// ----------------------------------------------------------------------------
// path to a score: product and sum registers, sums queue, scorer take, product steps,
// the bitwise search passes, then the output queue; a zero norm skips the search
// throughput: one pair per cycle while fewer than QDEPTH vectors wait for scoring
// the scorer sets the pace: it takes the next vector only after handing on its score
// reset: synchronous active low, clears sums, queues and the scorer state
module cosine_similarity_top #(
    parameter int ELEM_WIDTH = cos_sim_pkg::ELEM_WIDTH,
    parameter int QDEPTH     = cos_sim_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [ELEM_WIDTH-1:0]  i_a_elem,
    input  logic signed [ELEM_WIDTH-1:0]  i_b_elem,
    input  logic                          i_last,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [15:0]            o_score,
    output logic                          o_zero_norm
);
    localparam int SUMW = $bits(cos_sim_pkg::t_sums);
    localparam int CW   = $clog2(QDEPTH+1);
    localparam int RW   = 17;

    logic               w_acc_v, w_take, w_sv, w_sempty, w_oempty;
    cos_sim_pkg::t_sums w_sums, w_qsums;
    logic [SUMW-1:0]    w_qdata;
    logic [CW-1:0]      w_scnt, w_ocnt;
    logic [2:0]         r_inflight;
    logic signed [15:0] w_score;
    logic               w_zn;
    logic [RW-1:0]      w_odata;
    logic               w_opush;

    // a transaction is accepted on push & !full
    logic w_in;
    assign w_in = push && !full;

    // count of last marks still in the two-stage accumulator pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_inflight <= '0;
        else r_inflight <= r_inflight + 3'(w_in && i_last) - 3'(w_acc_v);
    end

    // hold input when the sums queue could overflow
    assign full = (32'(w_scnt) + 32'(r_inflight) + 32'd1) > 32'(QDEPTH);

    cos_sim_acc #(.ELEM_W(ELEM_WIDTH)) u_acc (
        .i_clk, .i_rst_n,
        .i_valid(w_in), .i_a(i_a_elem), .i_b(i_b_elem), .i_last(i_last),
        .o_valid(w_acc_v), .o_sums(w_sums)
    );

    cos_sim_fifo #(.DEPTH(QDEPTH), .WIDTH(SUMW)) u_sq (
        .i_clk, .i_rst_n,
        .i_push(w_acc_v), .i_data(w_sums), .i_pop(w_take),
        .o_empty(w_sempty), .o_count(w_scnt), .o_data(w_qdata)
    );
    assign w_qsums = w_qdata;

    // scorer hands its result into the output queue when it has room
    logic w_oready;
    assign w_oready = (w_ocnt < CW'(QDEPTH));
    assign w_opush  = w_sv && w_oready;

    cos_sim_score u_score (
        .i_clk, .i_rst_n,
        .i_valid(!w_sempty), .i_sums(w_qsums), .o_take(w_take),
        .o_valid(w_sv), .o_score(w_score), .o_zero_norm(w_zn),
        .i_ready(w_oready)
    );

    cos_sim_fifo #(.DEPTH(QDEPTH), .WIDTH(RW)) u_oq (
        .i_clk, .i_rst_n,
        .i_push(w_opush), .i_data({w_zn, w_score}), .i_pop(pop && !w_oempty),
        .o_empty(w_oempty), .o_count(w_ocnt), .o_data(w_odata)
    );

    assign empty       = w_oempty;
    assign o_score     = w_odata[15:0];
    assign o_zero_norm = w_odata[16];
endmodule

// ===== hw/rtl/cos_sim_checker.sv =====
// ----------------------------------------------------------------------------
// cos_sim_checker
// port-level checks on the cosine similarity block
// ----------------------------------------------------------------------------
module cos_sim_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_score,
    input logic        o_zero_norm
);
    // a zero norm always reads as -1.0
    a_zero_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_zero_norm) |-> (o_score == 16'h8000))
        else $error("zero norm without -1.0 score");

    // waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_score) && $stable(o_zero_norm)))
        else $error("result changed while waiting");

    // nothing to read right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result after reset");

    // input side open right after reset
    a_rst_full: assert property (@(posedge i_clk)
        !i_rst_n |=> !full)
        else $error("input blocked after reset");
endmodule

bind cosine_similarity_top cos_sim_checker u_chk (
    .i_clk, .i_rst_n, .push, .full, .empty, .pop, .o_score, .o_zero_norm
);

// ===== test/tb_cosine_similarity_top.sv =====
// ----------------------------------------------------------------------------
// tb_cosine_similarity_top
// streams random and directed vector pairs into the cosine similarity block,
// predicts each q1.15 score with an exact bitwise root search and checks
// every popped score and zero-norm flag in order
// ----------------------------------------------------------------------------
module tb_cosine_similarity_top;

    localparam int EW = cos_sim_pkg::ELEM_WIDTH;
    localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;
    localparam int LIMIT_CYCLES = 2000000;

    typedef struct packed {
        logic signed [EW-1:0] a;
        logic signed [EW-1:0] b;
        logic                 last;
        logic                 hold; // wait for all scores before this one
    } t_pair;

    typedef struct packed {
        logic signed [15:0] score;
        logic               zero_norm;
    } t_score;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic signed [EW-1:0] i_a_elem = '0;
    logic signed [EW-1:0] i_b_elem = '0;
    logic i_last = 1'b0;
    logic full, empty, o_zero_norm;
    logic signed [15:0] o_score;

    t_pair  pending_pairs[$];
    t_score expected_scores[$];
    logic signed [47:0] dot_acc = '0, norm_a_acc = '0, norm_b_acc = '0;
    int  error_count = 0;
    int  vector_count = 0;
    int  zero_norm_count = 0;
    int  cycle_count = 0;
    bit  stimulus_done = 1'b0;

    cosine_similarity_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_a_elem(i_a_elem), .i_b_elem(i_b_elem), .i_last(i_last),
        .empty(empty), .pop(pop),
        .o_score(o_score), .o_zero_norm(o_zero_norm)
    );

    always #5 i_clk = ~i_clk;

    // saturating add of a product into a 48-bit sum
    function automatic logic signed [47:0] sat_sum(logic signed [47:0] acc,
                                                   logic signed [63:0] p);
        logic signed [63:0] s;
        s = 64'(acc) + p;
        if (s > 64'(SUM_MAX)) return SUM_MAX;
        if (s < 64'(SUM_MIN)) return SUM_MIN;
        return s[47:0];
    endfunction

    // largest q with q*sqrt(na*nb) <= |dot|*2^15, sign applied and capped
    function automatic logic signed [15:0] cosine_score(logic signed [47:0] dot,
                                                        logic signed [47:0] na,
                                                        logic signed [47:0] nb);
        logic [127:0] norm_prod, dot_sq, trial_q, mag;
        logic [16:0] q;
        mag = dot < 0 ? 128'(-64'(dot)) : 128'(dot);
        norm_prod = 128'(na) * 128'(nb);
        dot_sq = (mag * mag) << 30;
        q = '0;
        for (int bit_i = 15; bit_i >= 0; bit_i--) begin
            trial_q = 128'(q | (17'd1 << bit_i));
            if (norm_prod * trial_q * trial_q <= dot_sq) q = trial_q[16:0];
        end
        if (dot < 0) begin
            if (q > 17'd32768) q = 17'd32768;
            return 16'(-q);
        end
        if (q > 17'd32767) q = 17'd32767;
        return q[15:0];
    endfunction

    // fold one accepted pair into the running sums, queue a score on last
    task automatic track_pair(t_pair p);
        logic signed [47:0] d, na, nb;
        t_score s;
        d  = sat_sum(dot_acc, 64'(p.a) * 64'(p.b));
        na = sat_sum(norm_a_acc, 64'(p.a) * 64'(p.a));
        nb = sat_sum(norm_b_acc, 64'(p.b) * 64'(p.b));
        if (!p.last) begin
            dot_acc = d; norm_a_acc = na; norm_b_acc = nb;
        end else begin
            if (na == 0 || nb == 0) begin
                s.score = 16'sh8000;
                s.zero_norm = 1'b1;
                zero_norm_count++;
            end else begin
                s.score = cosine_score(d, na, nb);
                s.zero_norm = 1'b0;
            end
            expected_scores = {expected_scores, s};
            vector_count++;
            dot_acc = '0; norm_a_acc = '0; norm_b_acc = '0;
        end
    endtask

    function automatic logic signed [EW-1:0] rand_elem(int mode);
        case (mode)
            0: return EW'($urandom);
            1: return $urandom_range(0, 3) == 0 ? 16'sh8000 : 16'sh7FFF;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom_range(0, 8191)) - 16'sd4096;
        endcase
    endfunction

    task automatic add_pair(logic signed [EW-1:0] a,
                            logic signed [EW-1:0] b, logic last);
        t_pair p;
        p.a = a; p.b = b; p.last = last; p.hold = 1'b0;
        pending_pairs = {pending_pairs, p};
    endtask

    // directed vectors followed by random ones of mostly short length
    initial begin
        int len, mode, relation;
        logic signed [EW-1:0] a, b;
        bit hold_set;
        hold_set = 1'b0;
        // single-element vectors at the extremes
        add_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        add_pair(16'sh8000, 16'sh8000, 1'b1);
        add_pair(16'sh8000, 16'sh7FFF, 1'b1);
        add_pair(16'sh7FFF, 16'sh8000, 1'b1);
        // zero norm on one side, the other, and both
        add_pair(16'sd0, 16'sd100, 1'b1);
        add_pair(16'sd100, 16'sd0, 1'b1);
        add_pair(16'sd0, 16'sd0, 1'b0);
        add_pair(16'sd0, 16'sd0, 1'b1);
        // orthogonal, opposite, tiny values
        add_pair(16'sd4096, 16'sd0, 1'b0);
        add_pair(16'sd0, 16'sd4096, 1'b1);
        add_pair(16'sd1, -16'sd1, 1'b1);
        add_pair(16'sd3, 16'sd5, 1'b0);
        add_pair(-16'sd7, 16'sd2, 1'b1);
        // a twelve-pair full-scale vector; its sums stay far below saturation
        for (int i = 0; i < 12; i++) add_pair(16'sh8000, 16'sh8000, i == 11);
        // random part; one vector in the middle is held until the queue drains
        while (pending_pairs.size() < 1300) begin
            len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 200) : $urandom_range(1, 12);
            mode = $urandom_range(0, 3);
            relation = $urandom_range(0, 4);
            for (int i = 0; i < len; i++) begin
                a = rand_elem(mode);
                case (relation)
                    0: b = a;
                    1: b = -a;
                    2: b = 16'($urandom_range(0, 1)) == 0 ? a >>> 1 : rand_elem(mode);
                    default: b = rand_elem(mode);
                endcase
                if ($urandom_range(0, 30) == 0) a = '0;
                add_pair(a, b, i == len - 1);
            end
            if (pending_pairs.size() > 600 && !hold_set) begin
                pending_pairs[pending_pairs.size() - 1].hold = 1'b1;
                hold_set = 1'b1;
            end
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: one transaction per accepted push, random gaps between them
    int  send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                track_pair({i_a_elem, i_b_elem, i_last, 1'b0});
                void'(pending_pairs.pop_front());
                send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
            end
            if (!(push && full)) begin
                if (pending_pairs.size() == 0) begin
                    push <= 1'b0;
                    stimulus_done = 1'b1;
                end else if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (pending_pairs[0].hold && expected_scores.size() != 0) begin
                    // pause until every queued score has been popped
                    push <= 1'b0;
                end else begin
                    push     <= 1'b1;
                    i_a_elem <= pending_pairs[0].a;
                    i_b_elem <= pending_pairs[0].b;
                    i_last   <= pending_pairs[0].last;
                end
            end
        end
    end

    // monitor: compare each popped transaction with the oldest expectation
    int  pop_wait = 0;
    always @(posedge i_clk) begin
        t_score exp_s;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_scores.size() == 0) begin
                    $error("unexpected score transaction: score %0d zero_norm %0b",
                           o_score, o_zero_norm);
                    error_count++;
                end else begin
                    exp_s = expected_scores.pop_front();
                    if (o_score !== exp_s.score) begin
                        $error("score: expected %0d, actual %0d", exp_s.score, o_score);
                        error_count++;
                    end
                    if (o_zero_norm !== exp_s.zero_norm) begin
                        $error("zero_norm: expected %0b, actual %0b",
                               exp_s.zero_norm, o_zero_norm);
                        error_count++;
                    end
                end
                pop_wait = $urandom_range(0, 2) == 0 ? $urandom_range(0, 18) : 0;
            end
            if (pop_wait > 0) begin
                pop_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // end of run: drain, settle, report; hard cycle limit as the timeout
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES) begin
                $display("tb_cosine_similarity_top: done, errors");
                $finish;
            end
            if (stimulus_done && expected_scores.size() == 0) break;
        end
        repeat (200) @(posedge i_clk);
        if (!empty) begin
            $error("score transaction left over after the drain");
            error_count++;
        end
        $display("covered %0d vectors (%0d with a zero norm) over %0d cycles",
                 vector_count, zero_norm_count, cycle_count);
        if (error_count == 0) begin
            $display("tb_cosine_similarity_top: done, clean");
        end else begin
            $display("tb_cosine_similarity_top: done, errors");
        end
        $finish;
    end

endmodule
